/* rtl/arx_permutation_32_macros.svh */
// Assertion macros shared by the ARX permutation RTL.
// Expects i_clk and i_rst_n in the including scope.
`ifndef ARX_PERMUTATION_32_MACROS_SVH
`define ARX_PERMUTATION_32_MACROS_SVH

// same-cycle implication
`define ARX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/arx_pkg.sv */
// Package for the ARX permutation: tuple type, round constants and the
// mu / nu / sigma tuple functions. No dependencies.
`timescale 1ns / 1ps

package arx_pkg;

    localparam int WORD_W     = 32;
    localparam int ROUND_W    = 2;
    localparam int TUPLES_DEF = 4;

    typedef logic [3:0][WORD_W-1:0] t_tuple;
    typedef logic [ROUND_W-1:0]     t_round;

    typedef struct packed {
        logic load_we;
        logic mix_en;
        logic sum_en;
        logic fwd;
        logic first;
    } t_dp_cmd;

    localparam logic [3:0][WORD_W-1:0] MU_K = {
        32'hC6C5C3B8, 32'hD1CCCAC9, 32'hE1D8D4D2, 32'hF0E8E4E2};
    localparam logic [3:0][WORD_W-1:0] NU_K = {
        32'h9695938E, 32'hA39C9A99, 32'hAAA9A6A5, 32'hB4B2B1AC};

    localparam logic [23:0][WORD_W-1:0] ROUND_K = {
        32'h473C3A39, 32'h534E4D4B, 32'h5A595655, 32'h6665635C,
        32'h716C6A69, 32'h87787472, 32'h938E8D8B, 32'h9A999695,
        32'hA6A5A39C, 32'hB1ACAAA9, 32'hC3B8B4B2, 32'hCAC9C6C5,
        32'hD4D2D1CC, 32'hE4E2E1D8, 32'h170FF0E8, 32'h271E1D1B,
        32'h332E2D2B, 32'h3A393635, 32'h4D4B473C, 32'h5655534E,
        32'h635C5A59, 32'h6A696665, 32'h7472716C, 32'h8D8B8778};

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
        logic [2*WORD_W-1:0] d;
        d = {v, v} << s;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    // constant tuple of a round; sel picks the first (0) or second (1) half
    function automatic t_tuple round_const(input t_round r, input logic sel);
        t_tuple t;
        int     base;
        unique case (r)
            2'd1:    base = 8;
            2'd2:    base = 16;
            default: base = 0;
        endcase
        if (sel) begin
            base = base + 4;
        end
        for (int j = 0; j < 4; j++) begin
            t[j] = ROUND_K[base + j];
        end
        return t;
    endfunction

    function automatic t_tuple mu(input t_tuple x);
        logic [WORD_W-1:0] s0, s1, s2, s3, a0, a1, a2, a3;
        t_tuple m;
        s0 = MU_K[0] + x[0] + x[1] + x[2];
        s1 = MU_K[1] + x[0] + x[1] + x[3];
        s2 = MU_K[2] + x[0] + x[2] + x[3];
        s3 = MU_K[3] + x[1] + x[2] + x[3];
        a0 = rotl(s0, 5);
        a1 = rotl(s1, 11);
        a2 = rotl(s2, 17);
        a3 = rotl(s3, 23);
        m[0] = a0 ^ a1 ^ a3;
        m[1] = a0 ^ a1 ^ a2;
        m[2] = a1 ^ a2 ^ a3;
        m[3] = a0 ^ a2 ^ a3;
        return m;
    endfunction

    function automatic t_tuple nu(input t_tuple y);
        logic [WORD_W-1:0] s0, s1, s2, s3, a0, a1, a2, a3;
        t_tuple n;
        s0 = NU_K[0] + y[0] + y[2] + y[3];
        s1 = NU_K[1] + y[1] + y[2] + y[3];
        s2 = NU_K[2] + y[0] + y[1] + y[2];
        s3 = NU_K[3] + y[0] + y[1] + y[3];
        a0 = rotl(s0, 3);
        a1 = rotl(s1, 10);
        a2 = rotl(s2, 19);
        a3 = rotl(s3, 29);
        n[0] = a1 ^ a2 ^ a3;
        n[1] = a0 ^ a2 ^ a3;
        n[2] = a0 ^ a1 ^ a3;
        n[3] = a0 ^ a1 ^ a2;
        return n;
    endfunction

    function automatic t_tuple sigma(input t_tuple m, input t_tuple n);
        t_tuple z;
        z[3] = m[0] + n[0];
        z[0] = m[1] + n[1];
        z[1] = m[2] + n[2];
        z[2] = m[3] + n[3];
        return z;
    endfunction

endpackage

/* rtl/arx_if.sv */
// Valid/ready channel interfaces for tuple input and permuted tuple output.
// Depends on arx_pkg.
`timescale 1ns / 1ps

interface arx_in_if;
    import arx_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] in_word_0;
    logic [WORD_W-1:0] in_word_1;
    logic [WORD_W-1:0] in_word_2;
    logic [WORD_W-1:0] in_word_3;
    modport source (output valid, in_word_0, in_word_1, in_word_2, in_word_3, input ready);
    modport sink   (input valid, in_word_0, in_word_1, in_word_2, in_word_3, output ready);
endinterface

interface arx_out_if;
    import arx_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word_0;
    logic [WORD_W-1:0] out_word_1;
    logic [WORD_W-1:0] out_word_2;
    logic [WORD_W-1:0] out_word_3;
    logic              out_last;
    modport source (output valid, out_word_0, out_word_1, out_word_2, out_word_3, out_last,
                    input ready);
    modport sink   (input valid, out_word_0, out_word_1, out_word_2, out_word_3, out_last,
                    output ready);
endinterface

/* rtl/arx_ctrl.sv */
// Controller FSM: load / mix / sum / emit sequencing, tuple and round counters,
// round count register. Depends on arx_pkg.
`timescale 1ns / 1ps

module arx_ctrl #(
    parameter int TUPLES = arx_pkg::TUPLES_DEF,
    parameter int IW     = $clog2(TUPLES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_out_last,
    input  logic                     i_cfg_we,
    input  logic [arx_pkg::ROUND_W-1:0] i_cfg_data,
    output arx_pkg::t_dp_cmd         o_cmd,
    output logic [IW-1:0]            o_idx,
    output arx_pkg::t_round          o_round
);
    import arx_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_MIX  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    localparam logic [IW-1:0] LAST_IDX = IW'(TUPLES - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    t_round        r_round, n_round;
    t_round        r_rounds, n_rounds;
    t_round        r_cfg;
    logic          r_fwd, n_fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_idx    <= '0;
            r_round  <= '0;
            r_rounds <= '0;
            r_fwd    <= 1'b1;
            r_cfg    <= 2'd3;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_round  <= n_round;
            r_rounds <= n_rounds;
            r_fwd    <= n_fwd;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_round     = r_round;
        n_rounds    = r_rounds;
        n_fwd       = r_fwd;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.load_we = i_in_valid;
                if (i_in_valid) begin
                    if (r_idx == LAST_IDX) begin
                        n_idx    = '0;
                        n_round  = '0;
                        n_rounds = r_cfg;
                        n_fwd    = 1'b1;
                        n_state  = (r_cfg == '0) ? ST_EMIT : ST_MIX;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_MIX: begin
                o_cmd.mix_en = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = ST_MIX;
                if (r_fwd) begin
                    // backward chain starts at the last tuple
                    if (r_idx == LAST_IDX) begin
                        n_fwd = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (r_idx == '0) begin
                    if (t_round'(r_round + 1'b1) == r_rounds) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_round = r_round + 1'b1;
                        n_fwd   = 1'b1;
                    end
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
        o_cmd.fwd   = r_fwd;
        o_cmd.first = r_fwd ? (r_idx == '0) : (r_idx == LAST_IDX);
    end

    assign o_out_last = (r_idx == LAST_IDX);
    assign o_idx      = r_idx;
    assign o_round    = r_round;

endmodule

/* rtl/arx_datapath.sv */
// Datapath: tuple and chain stores, ARX step split into mix (mu/nu) and
// sum (sigma) registers. Depends on arx_pkg.
`timescale 1ns / 1ps

module arx_datapath #(
    parameter int TUPLES = arx_pkg::TUPLES_DEF,
    parameter int IW     = $clog2(TUPLES)
) (
    input  logic             i_clk,
    input  arx_pkg::t_dp_cmd i_cmd,
    input  logic [IW-1:0]    i_idx,
    input  arx_pkg::t_round  i_round,
    input  arx_pkg::t_tuple  i_load,
    output arx_pkg::t_tuple  o_tuple
);
    import arx_pkg::*;

    t_tuple r_tuple [TUPLES];
    t_tuple r_chain [TUPLES];
    t_tuple r_prev;
    t_tuple r_m;
    t_tuple r_n;
    t_tuple s_x;
    t_tuple s_y;
    t_tuple s_z;

    // forward: x = previous chain value (round constant first), y = tuple
    // backward: x = chain entry, y = previous result (round constant first)
    always_comb begin
        if (i_cmd.fwd) begin
            s_x = i_cmd.first ? round_const(i_round, 1'b0) : r_prev;
            s_y = r_tuple[i_idx];
        end else begin
            s_x = r_chain[i_idx];
            s_y = i_cmd.first ? round_const(i_round, 1'b1) : r_prev;
        end
    end

    assign s_z = sigma(r_m, r_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_en) begin
            r_m <= mu(s_x);
            r_n <= nu(s_y);
        end
        if (i_cmd.sum_en) begin
            r_prev <= s_z;
            if (i_cmd.fwd) begin
                r_chain[i_idx] <= s_z;
            end
        end
        if (i_cmd.load_we || (i_cmd.sum_en && !i_cmd.fwd)) begin
            r_tuple[i_idx] <= i_cmd.load_we ? i_load : s_z;
        end
    end

    assign o_tuple = r_tuple[i_idx];

endmodule

/* rtl/arx_permutation_32.sv */
// Top level of the ARX permutation: controller, datapath, channel wiring.
// Depends on arx_pkg, arx_if, arx_ctrl, arx_datapath and the macros header.
//
//  port                       dir  role
//  i_in_ch                    in   tuple load, valid/ready transfer
//  o_out_ch                   out  permuted tuple, valid/ready transfer, out_last on the final one
//  i_cfg_we / i_cfg_round_count_setting  in  round count register write
//
// One tuple is taken per cycle while loading; nothing is taken during rounds or emit.
// During rounds each ARX step runs as mix, then sum, on one unit.
// Output stalls hold the current tuple; the next block loads after the last transfer.
// Reset is synchronous, active low; round count resets to 3.
`timescale 1ns / 1ps
`include "arx_permutation_32_macros.svh"

module arx_permutation_32 #(
    parameter int TUPLES = arx_pkg::TUPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    arx_in_if.sink                      i_in_ch,
    arx_out_if.source                   o_out_ch,
    input  logic                        i_cfg_we,
    input  logic [arx_pkg::ROUND_W-1:0] i_cfg_round_count_setting
);
    import arx_pkg::*;

    localparam int IW = $clog2(TUPLES);

    t_dp_cmd       s_cmd;
    logic [IW-1:0] s_idx;
    t_round        s_round;
    t_tuple        s_load;
    t_tuple        s_tuple;

    assign s_load = {i_in_ch.in_word_3, i_in_ch.in_word_2, i_in_ch.in_word_1,
                     i_in_ch.in_word_0};

    arx_ctrl #(
        .TUPLES (TUPLES),
        .IW     (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_out_last  (o_out_ch.out_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_round_count_setting),
        .o_cmd       (s_cmd),
        .o_idx       (s_idx),
        .o_round     (s_round)
    );

    arx_datapath #(
        .TUPLES (TUPLES),
        .IW     (IW)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_cmd   (s_cmd),
        .i_idx   (s_idx),
        .i_round (s_round),
        .i_load  (s_load),
        .o_tuple (s_tuple)
    );

    assign o_out_ch.out_word_0 = s_tuple[0];
    assign o_out_ch.out_word_1 = s_tuple[1];
    assign o_out_ch.out_word_2 = s_tuple[2];
    assign o_out_ch.out_word_3 = s_tuple[3];

    `ARX_ASSERT_IMP(a_in_out_exclusive, i_in_ch.ready, !o_out_ch.valid, "load and emit overlap")
    `ARX_ASSERT_NXT(a_mix_then_sum, s_cmd.mix_en, s_cmd.sum_en, "mix not followed by sum")
    `ARX_ASSERT_NXT(a_last_to_load, o_out_ch.valid && o_out_ch.ready && o_out_ch.out_last, i_in_ch.ready && !o_out_ch.valid, "no return to load after last transfer")

endmodule

/* dv/arx_permutation_32_test.sv */
// Testbench for arx_permutation_32: loads 4-tuple states, predicts the Pi32 ARX permutation
// internally and checks every permuted tuple transfer. Depends on arx_pkg, arx_if and the RTL.
`timescale 1ns / 1ps

module arx_permutation_32_test;
    import arx_pkg::*;

    localparam int TUPLES        = TUPLES_DEF;
    localparam int IDLE_PCT      = 35;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 64;
    localparam int QUIET_LIMIT   = 2000;
    localparam int STEADY_FROM   = 800;
    localparam int STEADY_TO     = 1400;
    localparam int RANDOM_BLOCKS = 38;

    typedef logic [3:0][WORD_W-1:0] t_quad;

    typedef enum logic [1:0] {
        ENTRY_TUPLE,
        ENTRY_PAUSE,
        ENTRY_ROUNDS
    } t_entry_kind;

    typedef struct {
        t_entry_kind  kind;
        t_quad        tuple;
        logic [ROUND_W-1:0] rounds;
    } t_pending;

    typedef struct {
        t_quad words;
        logic  last;
    } t_perm_tuple;

    localparam logic [31:0] MU_C [4] = '{32'hF0E8E4E2, 32'hE1D8D4D2, 32'hD1CCCAC9, 32'hC6C5C3B8};
    localparam logic [31:0] NU_C [4] = '{32'hB4B2B1AC, 32'hAAA9A6A5, 32'hA39C9A99, 32'h9695938E};
    localparam logic [31:0] RK [24] = '{
        32'h8D8B8778, 32'h7472716C, 32'h6A696665, 32'h635C5A59,
        32'h5655534E, 32'h4D4B473C, 32'h3A393635, 32'h332E2D2B,
        32'h271E1D1B, 32'h170FF0E8, 32'hE4E2E1D8, 32'hD4D2D1CC,
        32'hCAC9C6C5, 32'hC3B8B4B2, 32'hB1ACAAA9, 32'hA6A5A39C,
        32'h9A999695, 32'h938E8D8B, 32'h87787472, 32'h716C6A69,
        32'h6665635C, 32'h5A595655, 32'h534E4D4B, 32'h473C3A39};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [ROUND_W-1:0] i_cfg_round_count_setting = 2'd3;

    arx_in_if  in_ch ();
    arx_out_if out_ch ();

    arx_permutation_32 #(.TUPLES(TUPLES)) DUT (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_in_ch                   (in_ch),
        .o_out_ch                  (out_ch),
        .i_cfg_we                  (i_cfg_we),
        .i_cfg_round_count_setting (i_cfg_round_count_setting)
    );

    t_pending           pending [$];
    t_perm_tuple        permuted_due [$];
    t_quad              state_tuples [TUPLES];
    t_quad              chain_tuples [TUPLES];
    int                 load_cnt;
    logic [ROUND_W-1:0] round_setting = 2'd3;
    int                 mismatches;
    int                 settle_cnt;
    int                 quiet_cnt;
    int                 cycle_cnt;
    t_pending           head;
    t_perm_tuple        want;
    t_quad              got;
    logic               send_valid;
    logic               write_cfg;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] rol(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // sigma(mu(x), nu(y))
    function automatic t_quad pi_arx(input t_quad x, input t_quad y);
        logic [31:0] a0, a1, a2, a3, m0, m1, m2, m3, n0, n1, n2, n3;
        t_quad       z;
        a0 = rol(MU_C[0] + x[0] + x[1] + x[2], 5);
        a1 = rol(MU_C[1] + x[0] + x[1] + x[3], 11);
        a2 = rol(MU_C[2] + x[0] + x[2] + x[3], 17);
        a3 = rol(MU_C[3] + x[1] + x[2] + x[3], 23);
        m0 = a0 ^ a1 ^ a3;
        m1 = a0 ^ a1 ^ a2;
        m2 = a1 ^ a2 ^ a3;
        m3 = a0 ^ a2 ^ a3;
        a0 = rol(NU_C[0] + y[0] + y[2] + y[3], 3);
        a1 = rol(NU_C[1] + y[1] + y[2] + y[3], 10);
        a2 = rol(NU_C[2] + y[0] + y[1] + y[2], 19);
        a3 = rol(NU_C[3] + y[0] + y[1] + y[3], 29);
        n0 = a1 ^ a2 ^ a3;
        n1 = a0 ^ a2 ^ a3;
        n2 = a0 ^ a1 ^ a3;
        n3 = a0 ^ a1 ^ a2;
        z[3] = m0 + n0;
        z[0] = m1 + n1;
        z[1] = m2 + n2;
        z[2] = m3 + n3;
        return z;
    endfunction

    // store one loaded tuple; a full state is permuted and its tuples queued as due
    function automatic void absorb_tuple(input t_quad t);
        t_quad       cx, cy;
        t_perm_tuple r;
        state_tuples[load_cnt] = t;
        load_cnt++;
        if (load_cnt == TUPLES) begin
            load_cnt = 0;
            for (int rnd = 0; rnd < round_setting; rnd++) begin
                for (int j = 0; j < 4; j++) begin
                    cx[j] = RK[rnd * 8 + j];
                    cy[j] = RK[rnd * 8 + 4 + j];
                end
                chain_tuples[0] = pi_arx(cx, state_tuples[0]);
                for (int i = 1; i < TUPLES; i++) begin
                    chain_tuples[i] = pi_arx(chain_tuples[i-1], state_tuples[i]);
                end
                state_tuples[TUPLES-1] = pi_arx(chain_tuples[TUPLES-1], cy);
                for (int i = TUPLES - 1; i > 0; i--) begin
                    state_tuples[i-1] = pi_arx(chain_tuples[i-1], state_tuples[i]);
                end
            end
            for (int i = 0; i < TUPLES; i++) begin
                r.words = state_tuples[i];
                r.last  = (i == TUPLES - 1);
                permuted_due.push_back(r);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    function automatic void queue_tuple(input t_quad t);
        t_pending p;
        p.kind   = ENTRY_TUPLE;
        p.tuple  = t;
        p.rounds = '0;
        pending.push_back(p);
    endfunction

    function automatic void queue_ctrl(input t_entry_kind kind, input logic [ROUND_W-1:0] r);
        t_pending p;
        p.kind   = kind;
        p.tuple  = '0;
        p.rounds = r;
        pending.push_back(p);
    endfunction

    function automatic logic [31:0] rand_word();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic logic steady();
        return cycle_cnt >= STEADY_FROM && cycle_cnt < STEADY_TO;
    endfunction

    // sender: tuple transfers, pauses and round count writes in queue order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            i_cfg_we    <= 1'b0;
            settle_cnt  <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_tuple({in_ch.in_word_3, in_ch.in_word_2, in_ch.in_word_1,
                              in_ch.in_word_0});
            end
            send_valid = in_ch.valid && !in_ch.ready;
            write_cfg  = 1'b0;
            if (!send_valid && pending.size() != 0) begin
                head = pending[0];
                if (head.kind == ENTRY_TUPLE) begin
                    if (steady() || $urandom_range(99, 0) >= IDLE_PCT) begin
                        pending.delete(0);
                        send_valid = 1'b1;
                        in_ch.in_word_0 <= head.tuple[0];
                        in_ch.in_word_1 <= head.tuple[1];
                        in_ch.in_word_2 <= head.tuple[2];
                        in_ch.in_word_3 <= head.tuple[3];
                    end
                end else if (permuted_due.size() != 0) begin
                    settle_cnt <= 0;
                end else if (settle_cnt < SETTLE_CYCLES) begin
                    settle_cnt <= settle_cnt + 1;
                end else begin
                    settle_cnt <= 0;
                    pending.delete(0);
                    if (head.kind == ENTRY_ROUNDS) begin
                        write_cfg = 1'b1;
                        i_cfg_round_count_setting <= head.rounds;
                        round_setting = head.rounds;
                    end
                end
            end
            in_ch.valid <= send_valid;
            i_cfg_we    <= write_cfg;
        end
    end

    // receiver: random stalls, each transfer checked against the oldest due tuple
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.out_word_3, out_ch.out_word_2, out_ch.out_word_1,
                       out_ch.out_word_0};
                if (permuted_due.size() == 0) begin
                    report_mismatch("unexpected transfer, word 0", '0, got[0]);
                end else begin
                    want = permuted_due.pop_front();
                    for (int j = 0; j < 4; j++) begin
                        if (got[j] !== want.words[j]) begin
                            report_mismatch($sformatf("out_word_%0d", j), want.words[j], got[j]);
                        end
                    end
                    if (out_ch.out_last !== want.last) begin
                        report_mismatch("out_last", 32'(want.last), 32'(out_ch.out_last));
                    end
                end
            end
            out_ch.ready <= steady() || $urandom_range(99, 0) >= IDLE_PCT;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cnt <= 0;
            cycle_cnt <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we) begin
                quiet_cnt <= 0;
            end else if (quiet_cnt == QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("** arx_permutation_32: FAILED **");
                $finish;
            end else begin
                quiet_cnt <= quiet_cnt + 1;
            end
        end
    end

    initial begin
        t_quad t;
        in_ch.valid     = 1'b0;
        in_ch.in_word_0 = '0;
        in_ch.in_word_1 = '0;
        in_ch.in_word_2 = '0;
        in_ch.in_word_3 = '0;
        out_ch.ready    = 1'b0;
        load_cnt        = 0;
        mismatches      = 0;

        // reset value of three rounds
        repeat (TUPLES) queue_tuple('0);
        queue_ctrl(ENTRY_ROUNDS, 2'd1);
        repeat (TUPLES) queue_tuple('1);
        for (int i = 0; i < TUPLES; i++) begin
            queue_tuple({4{i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA}});
        end
        queue_ctrl(ENTRY_ROUNDS, 2'd2);
        for (int i = 0; i < TUPLES; i++) begin
            t = '0;
            t[i % 4] = '1;
            queue_tuple(t);
        end
        queue_ctrl(ENTRY_ROUNDS, 2'd3);
        for (int i = 0; i < TUPLES; i++) begin
            queue_tuple({32'h8000_0001 << i, 32'h7FFF_FFFE, 32'h0000_0001, 32'hFFFF_FFFE});
        end

        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            if ($urandom_range(5, 0) == 0) begin
                queue_ctrl(ENTRY_ROUNDS, 2'($urandom_range(3, 1)));
            end else if ($urandom_range(9, 0) == 0) begin
                queue_ctrl(ENTRY_PAUSE, '0);
            end
            for (int i = 0; i < TUPLES; i++) begin
                for (int j = 0; j < 4; j++) begin
                    t[j] = rand_word();
                end
                queue_tuple(t);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending.size() != 0 || in_ch.valid || permuted_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** arx_permutation_32: PASSED **");
        end else begin
            $display("** arx_permutation_32: FAILED **");
        end
        $finish;
    end

endmodule
